>>> rtl/core/tvsa_pkg.sv
// Timed voice slot allocator: shared types and codes.
// No dependencies; used by timed_voice_slot_allocator.
package tvsa_pkg;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_PLAY = 2'd1;

    localparam logic [1:0] STAT_STARTED = 2'd0;
    localparam logic [1:0] STAT_NO_SLOT = 2'd1;
    localparam logic [1:0] STAT_STOPPED = 2'd2;
    localparam logic [1:0] STAT_TICKED  = 2'd3;

    localparam logic [31:0] DUR_MAX = 32'h8000_0000;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PLAY,
        S_TICK,
        S_TICK_END
    } t_state;

endpackage

>>> rtl/core/timed_voice_slot_allocator.sv
// Timed voice slot allocator top level: slot flags, stop-time memory and sequencer.
// Depends on tvsa_pkg.
//
// A word is accepted when i_start is high and o_busy is low. Stop all completes in the
// accepting cycle. Play scans the slot flags one slot per cycle from slot 0. Tick walks the
// stop-time memory one entry per cycle, with a registered read. The result word appears on
// the o_ ports, marked by o_valid, for exactly one cycle in the cycle after the work ends;
// it must be taken then, since it cannot be held off. A new word may be started in that
// same cycle.
module timed_voice_slot_allocator #(
    parameter int SLOT_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_duration_ms,
    input  logic [23:0] i_frequency,
    output logic        o_busy,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [2:0]  o_slot,
    output logic [23:0] o_slot_frequency,
    output logic [7:0]  o_active_mask,
    output logic [7:0]  o_expired_mask
);

    localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [SW-1:0] LAST = SW'(SLOT_COUNT - 1);

    tvsa_pkg::t_state r_state, n_state;

    logic [SLOT_COUNT-1:0] r_active, n_active;
    logic [SLOT_COUNT-1:0] r_timed,  n_timed;
    logic [SLOT_COUNT-1:0] r_exp,    n_exp;
    logic [31:0]           r_now,    n_now;
    logic [31:0]           r_dur,    n_dur;
    logic [23:0]           r_freq,   n_freq;
    logic [SW-1:0]         r_idx,    n_idx;
    logic [SW-1:0]         r_chk_idx, n_chk_idx;
    logic                  r_chk_vld, n_chk_vld;

    logic                  r_valid,  n_valid;
    logic [1:0]            r_status, n_status;
    logic [2:0]            r_slot,   n_slot;
    logic [23:0]           r_sfreq,  n_sfreq;
    logic [7:0]            r_amask,  n_amask;
    logic [7:0]            r_emask,  n_emask;

    logic [31:0]           mem [SLOT_COUNT];
    logic [31:0]           r_rd_data;
    logic                  mem_we;
    logic [31:0]           diff;

    function automatic logic [7:0] low8(input logic [SLOT_COUNT-1:0] v);
        logic [7:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (b < SLOT_COUNT) begin
                m[b] = v[b];
            end
        end
        return m;
    endfunction

    function automatic logic [2:0] slot3(input logic [SW-1:0] v);
        logic [2:0] s;
        s = '0;
        for (int b = 0; b < 3; b++) begin
            if (b < SW) begin
                s[b] = v[b];
            end
        end
        return s;
    endfunction

    // stop-time memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_idx] <= r_now + r_dur;
        end
        r_rd_data <= mem[r_idx];
    end

    assign diff = r_now - r_rd_data;

    always_comb begin
        n_state   = r_state;
        n_active  = r_active;
        n_timed   = r_timed;
        n_exp     = r_exp;
        n_now     = r_now;
        n_dur     = r_dur;
        n_freq    = r_freq;
        n_idx     = r_idx;
        n_chk_idx = r_chk_idx;
        n_chk_vld = r_chk_vld;
        n_valid   = 1'b0;
        n_status  = r_status;
        n_slot    = r_slot;
        n_sfreq   = r_sfreq;
        n_amask   = r_amask;
        n_emask   = r_emask;
        mem_we    = 1'b0;

        case (r_state)
            tvsa_pkg::S_IDLE: begin
                if (i_start) begin
                    n_dur     = (i_duration_ms > tvsa_pkg::DUR_MAX) ? tvsa_pkg::DUR_MAX
                                                                    : i_duration_ms;
                    n_freq    = i_frequency;
                    n_idx     = '0;
                    n_chk_vld = 1'b0;
                    n_exp     = '0;
                    if (i_operation[1]) begin
                        n_active = '0;
                        n_timed  = '0;
                        n_valid  = 1'b1;
                        n_status = tvsa_pkg::STAT_STOPPED;
                        n_slot   = '0;
                        n_sfreq  = '0;
                    end else if (i_operation == tvsa_pkg::OP_PLAY) begin
                        n_state = tvsa_pkg::S_PLAY;
                    end else begin
                        n_now   = r_now + 32'd1;
                        n_state = tvsa_pkg::S_TICK;
                    end
                end
            end
            tvsa_pkg::S_PLAY: begin
                if (!r_active[r_idx]) begin
                    mem_we          = (r_dur != '0);
                    n_active[r_idx] = 1'b1;
                    n_timed[r_idx]  = (r_dur != '0);
                    n_valid         = 1'b1;
                    n_status        = tvsa_pkg::STAT_STARTED;
                    n_slot          = slot3(r_idx);
                    n_sfreq         = r_freq;
                    n_state         = tvsa_pkg::S_IDLE;
                end else if (r_idx == LAST) begin
                    n_valid  = 1'b1;
                    n_status = tvsa_pkg::STAT_NO_SLOT;
                    n_slot   = '0;
                    n_sfreq  = '0;
                    n_state  = tvsa_pkg::S_IDLE;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            tvsa_pkg::S_TICK: begin
                n_chk_vld = 1'b1;
                n_chk_idx = r_idx;
                if (r_idx == LAST) begin
                    n_state = tvsa_pkg::S_TICK_END;
                end else begin
                    n_idx = r_idx + SW'(1);
                end
            end
            tvsa_pkg::S_TICK_END: begin
                n_valid   = 1'b1;
                n_chk_vld = 1'b0;
                n_status  = tvsa_pkg::STAT_TICKED;
                n_slot    = '0;
                n_sfreq   = '0;
                n_state   = tvsa_pkg::S_IDLE;
            end
            default: begin
                n_state = tvsa_pkg::S_IDLE;
            end
        endcase

        // expiry check on the entry read last cycle
        if ((r_state == tvsa_pkg::S_TICK || r_state == tvsa_pkg::S_TICK_END) && r_chk_vld
            && r_active[r_chk_idx] && r_timed[r_chk_idx] && !diff[31]) begin
            n_active[r_chk_idx] = 1'b0;
            n_timed[r_chk_idx]  = 1'b0;
            n_exp[r_chk_idx]    = 1'b1;
        end

        if (n_valid) begin
            n_amask = low8(n_active);
            n_emask = (r_state == tvsa_pkg::S_TICK_END) ? low8(n_exp) : 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= tvsa_pkg::S_IDLE;
            r_active  <= '0;
            r_timed   <= '0;
            r_now     <= '0;
            r_chk_vld <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_timed   <= n_timed;
            r_now     <= n_now;
            r_chk_vld <= n_chk_vld;
            r_valid   <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_exp     <= n_exp;
        r_dur     <= n_dur;
        r_freq    <= n_freq;
        r_idx     <= n_idx;
        r_chk_idx <= n_chk_idx;
        r_status  <= n_status;
        r_slot    <= n_slot;
        r_sfreq   <= n_sfreq;
        r_amask   <= n_amask;
        r_emask   <= n_emask;
    end

    assign o_busy           = (r_state != tvsa_pkg::S_IDLE);
    assign o_valid          = r_valid;
    assign o_status         = r_status;
    assign o_slot           = r_slot;
    assign o_slot_frequency = r_sfreq;
    assign o_active_mask    = r_amask;
    assign o_expired_mask   = r_emask;

    a_valid_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> !o_busy)
        else $error("result word while busy");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_valid || o_busy))
        else $error("accepted word neither answered nor in progress");

    a_timed_subset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_timed & ~r_active) == '0)
        else $error("timed mark on inactive slot");

    a_no_slot_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status == tvsa_pkg::STAT_NO_SLOT) |-> (&r_active))
        else $error("no-slot reported with a free slot");

    a_expiry_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_status != tvsa_pkg::STAT_TICKED) |-> (r_emask == 8'd0))
        else $error("expiry mask outside tick");

endmodule
